// ----- rtl/clm_pkg.sv -----
package clm_pkg;

    localparam int NUM_CORES      = 2;
    localparam int CORE_W         = 1;
    localparam int TS_W           = 64;
    localparam int DT_W           = 32;
    localparam int TASK_W         = 32;
    localparam int LOAD_W         = 7;
    localparam int WSUM_W         = 64;
    localparam int NUM_W          = DT_W + 7;
    localparam int DEN_W          = DT_W + 1;
    localparam int DIV_STEPS      = NUM_W;
    localparam int CNT_W          = 6;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [DT_W-1:0] INTERVAL_RESET = 32'd1000000;

    // Register index as decoded from the word address bit.
    localparam logic REG_INTERVAL = 1'b0;

    typedef struct packed {
        logic              done;
        logic [LOAD_W-1:0] quot;
    } t_div_res;

endpackage

// ----- rtl/clm_div.sv -----
module clm_div
    import clm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_res         o_res
);

    // Restoring divider: one numerator bit enters the remainder each cycle.
    // The quotient is known to stay below 128, so only its low bits are kept.
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [LOAD_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quot <= {r_quot[LOAD_W-2:0], fits};
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

endmodule

// ----- rtl/cpu_load_monitor.sv -----
// Per-core load monitor driven by task-switch beats. Each input beat charges
// the time since the previous beat to the idle or running accumulator of its
// core, recomputes that core's load as a percentage, and clears the core's
// accumulators and the shared window sum once the window reaches interval_us
// (register at byte address 0, reset value one million). One beat is worked
// on at a time: an accepted beat passes the DT, ACC and MUL update states,
// then the 39-step bit-serial divider that forms the percentage, then the
// OUT handover state. The next beat is taken the cycle after the result has
// been moved to the output register, even if it is still stalled there, so
// no input beat is accepted while an earlier one is still being worked on.
module cpu_load_monitor
    import clm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               i_valid,
    output logic               o_stall,
    input  logic [TS_W-1:0]    i_timestamp_us,
    input  logic [CORE_W-1:0]  i_core,
    input  logic [TASK_W-1:0]  i_task_id,
    input  logic               i_is_idle,
    input  logic [CORE_W-1:0]  i_query_core,

    output logic               o_valid,
    input  logic               i_stall,
    output logic [LOAD_W-1:0]  o_load_percent,
    output logic               o_window_cleared,
    output logic [LOAD_W-1:0]  o_query_load
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DT   = 6'b000010,
        S_ACC  = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [DT_W-1:0]   r_interval;
    logic [DT_W-1:0]   r_last_time;
    logic [WSUM_W-1:0] r_window_sum;
    logic [DT_W-1:0]   r_running_acc [NUM_CORES];
    logic [DT_W-1:0]   r_idle_acc    [NUM_CORES];
    logic [TASK_W-1:0] r_prev_task   [NUM_CORES];
    logic [LOAD_W-1:0] r_load_store  [NUM_CORES];

    // Captured beat and intermediate results.
    logic [DT_W-1:0]   r_ts;
    logic [CORE_W-1:0] r_core;
    logic [TASK_W-1:0] r_task;
    logic              r_is_idle;
    logic [CORE_W-1:0] r_query;
    logic [DT_W-1:0]   r_dt;
    logic              r_to_idle;
    logic              r_zero_den;
    logic              r_cleared;
    logic [LOAD_W-1:0] r_load;

    logic              r_out_valid;
    logic [LOAD_W-1:0] r_out_load;
    logic              r_out_cleared;
    logic [LOAD_W-1:0] r_out_query;

    logic              in_accept;
    logic              out_free;
    logic              cfg_write;
    logic [DT_W-1:0]   dt_raw;
    logic              same_task;
    logic [DT_W-1:0]   run_cur;
    logic [DT_W-1:0]   idle_cur;
    logic [NUM_W-1:0]  run_ext;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_start;
    t_div_res          div_res;

    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign cfg_write = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INTERVAL) ? r_interval : '0;

    always_comb begin
        dt_raw    = r_ts - r_last_time;
        same_task = (r_task == r_prev_task[r_core]);
        run_cur   = r_running_acc[r_core];
        idle_cur  = r_idle_acc[r_core];
        run_ext   = {{(NUM_W-DT_W){1'b0}}, run_cur};
        // run * 100 as a sum of three shifted copies
        div_num   = (run_ext << 6) + (run_ext << 5) + (run_ext << 2);
        div_den   = {1'b0, run_cur} + {1'b0, idle_cur};
        div_start = (r_state == S_MUL);
    end

    clm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_res   (div_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_accept) n_state = S_DT;
            S_DT:   n_state = S_ACC;
            S_ACC:  n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (div_res.done) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_interval   <= INTERVAL_RESET;
            r_last_time  <= '0;
            r_window_sum <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_CORES; i++) begin
                r_running_acc[i] <= '0;
                r_idle_acc[i]    <= '0;
                r_prev_task[i]   <= '0;
                r_load_store[i]  <= '0;
            end
        end else begin
            r_state <= n_state;

            if (cfg_write && (paddr[2] == REG_INTERVAL)) begin
                r_interval <= pwdata;
            end

            // A new result beat takes the output register as the old one leaves.
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_DT: begin
                    r_last_time         <= r_ts;
                    r_prev_task[r_core] <= r_task;
                end
                S_ACC: begin
                    if (r_to_idle) begin
                        r_idle_acc[r_core] <= r_idle_acc[r_core] + r_dt;
                    end else begin
                        r_running_acc[r_core] <= r_running_acc[r_core] + r_dt;
                    end
                    r_window_sum <= r_window_sum + {{(WSUM_W-DT_W){1'b0}}, r_dt};
                end
                S_MUL: begin
                    // The divider has already latched the pre-clear values.
                    if (r_window_sum >= {{(WSUM_W-DT_W){1'b0}}, r_interval}) begin
                        r_running_acc[r_core] <= '0;
                        r_idle_acc[r_core]    <= '0;
                        r_window_sum          <= '0;
                    end
                end
                S_DIV: begin
                    if (div_res.done) begin
                        r_load_store[r_core] <= r_zero_den ? '0 : div_res.quot;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ts      <= i_timestamp_us[DT_W-1:0];
            r_core    <= i_core;
            r_task    <= i_task_id;
            r_is_idle <= i_is_idle;
            r_query   <= i_query_core;
        end
        if (r_state == S_DT) begin
            r_dt      <= (dt_raw == '0) ? DT_W'(1) : dt_raw;
            // Idle to idle and idle to active are charged as idle time.
            r_to_idle <= r_is_idle ? same_task : !same_task;
        end
        if (r_state == S_MUL) begin
            r_zero_den <= (div_den == '0);
            r_cleared  <= (r_window_sum >= {{(WSUM_W-DT_W){1'b0}}, r_interval});
        end
        if ((r_state == S_DIV) && div_res.done) begin
            r_load <= r_zero_den ? '0 : div_res.quot;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out_load    <= r_load;
            r_out_cleared <= r_cleared;
            r_out_query   <= r_load_store[r_query];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_load_percent   = r_out_load;
    assign o_window_cleared = r_out_cleared;
    assign o_query_load     = r_out_query;

endmodule
